// ===== sv/rets_pkg.sv =====
// Shared types, widths, register indexes and reset values of the thrust sequencer.
package rets_pkg;

	localparam int OPCODE_W   = 2;
	localparam int THRUST_W   = 17;
	localparam int CFG_PW_W   = 12;
	localparam int CFG_MAX_W  = 16;
	localparam int WAIT_W     = 24;
	localparam int PW_W       = 13;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 24;

	// Product of an in-range magnitude and the span, and the divider that scales it.
	localparam int PROD_W    = CFG_MAX_W + CFG_PW_W;
	localparam int DIV_CNT_W = $clog2(PROD_W + 1);

	localparam logic [CFG_PW_W-1:0]  ZERO_PW_RST    = CFG_PW_W'(1100);
	localparam logic [CFG_PW_W-1:0]  PW_SPAN_RST    = CFG_PW_W'(1900 - 1100);
	localparam logic [CFG_MAX_W-1:0] THRUST_LIM_RST = CFG_MAX_W'(1000);
	localparam logic [WAIT_W-1:0]    ZERO_WAIT_RST  = WAIT_W'(500 * 1000);
	localparam logic [WAIT_W-1:0]    RELAY_WAIT_RST = WAIT_W'(6 * 1000);
	localparam logic [WAIT_W-1:0]    ARM_WAIT_RST   = WAIT_W'(2 * 1000 * 1000);

	localparam logic [CFG_ADDR_W-1:0] REG_ZERO_PW    = CFG_ADDR_W'(0);
	localparam logic [CFG_ADDR_W-1:0] REG_PW_SPAN    = CFG_ADDR_W'(1);
	localparam logic [CFG_ADDR_W-1:0] REG_THRUST_LIM = CFG_ADDR_W'(2);
	localparam logic [CFG_ADDR_W-1:0] REG_ZERO_WAIT  = CFG_ADDR_W'(3);
	localparam logic [CFG_ADDR_W-1:0] REG_RELAY_WAIT = CFG_ADDR_W'(4);
	localparam logic [CFG_ADDR_W-1:0] REG_ARM_WAIT   = CFG_ADDR_W'(5);

	localparam logic [OPCODE_W-1:0] OP_SET = OPCODE_W'(0);
	localparam logic [OPCODE_W-1:0] OP_ARM = OPCODE_W'(1);
	localparam logic [OPCODE_W-1:0] OP_OFF = OPCODE_W'(2);

	// Action kinds; the value is also the bit of the action in the pending mask.
	typedef enum logic [2:0] {
		ACT_ERR   = 3'd0,
		ACT_ARM   = 3'd1,
		ACT_ZERO  = 3'd2,
		ACT_RELAY = 3'd3,
		ACT_SET   = 3'd4,
		ACT_OFF   = 3'd5
	} act_t;

	localparam int NUM_ACT = 6;

	typedef struct packed {
		logic load;
		logic commit;
		logic mul;
		logic div_start;
		logic emit;
		act_t act;
		logic last;
		logic relay_val;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic                t_pos;
		logic                t_neg;
		logic                prev_pos;
		logic                prev_neg;
		logic                oor;
		logic                div_busy;
		logic                out_free;
	} dp_stat_t;

endpackage

// ===== sv/rets_dp.sv =====
// Datapath: configuration registers, command latch, direction state, scaling divider, result register.
module rets_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rets_pkg::ctrl_cmd_t                 cmd,
	output rets_pkg::dp_stat_t                  stat,
	input  logic                                cfg_we,
	input  logic [rets_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [rets_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic [rets_pkg::OPCODE_W-1:0]       in_opcode,
	input  logic [rets_pkg::THRUST_W-1:0]       in_thrust,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [rets_pkg::PW_W-1:0]           out_pulse_width,
	output logic                                out_relay_on,
	output logic [rets_pkg::WAIT_W-1:0]         out_wait_us,
	output logic                                out_error,
	output logic                                out_last
);
	import rets_pkg::*;

	logic [CFG_PW_W-1:0]  zero_pw_q;
	logic [CFG_PW_W-1:0]  pw_span_q;
	logic [CFG_MAX_W-1:0] thrust_lim_q;
	logic [WAIT_W-1:0]    zero_wait_q;
	logic [WAIT_W-1:0]    relay_wait_q;
	logic [WAIT_W-1:0]    arm_wait_q;

	logic [OPCODE_W-1:0]  op_q;
	logic [THRUST_W-1:0]  thr_q;
	logic                 prev_pos_q;
	logic                 prev_neg_q;
	logic                 relay_q;

	logic [THRUST_W-1:0]  mag;
	logic                 t_pos;
	logic                 t_neg;

	logic [PROD_W-1:0]    prod_q;
	logic [PROD_W-1:0]    quo_q;
	logic [CFG_MAX_W-1:0] rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [CFG_MAX_W:0]   trial;
	logic [CFG_MAX_W:0]   diff;
	logic                 qbit;
	logic                 div_busy;

	logic                 out_valid_q;
	logic                 out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_pw_q    <= ZERO_PW_RST;
			pw_span_q    <= PW_SPAN_RST;
			thrust_lim_q <= THRUST_LIM_RST;
			zero_wait_q  <= ZERO_WAIT_RST;
			relay_wait_q <= RELAY_WAIT_RST;
			arm_wait_q   <= ARM_WAIT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ZERO_PW:    zero_pw_q    <= cfg_wdata[CFG_PW_W-1:0];
				REG_PW_SPAN:    pw_span_q    <= cfg_wdata[CFG_PW_W-1:0];
				REG_THRUST_LIM: thrust_lim_q <= cfg_wdata[CFG_MAX_W-1:0];
				REG_ZERO_WAIT:  zero_wait_q  <= cfg_wdata[WAIT_W-1:0];
				REG_RELAY_WAIT: relay_wait_q <= cfg_wdata[WAIT_W-1:0];
				REG_ARM_WAIT:   arm_wait_q   <= cfg_wdata[WAIT_W-1:0];
				default: ;
			endcase
		end
	end

	// A power-off command runs the zero-thrust sequence, so its thrust is latched as zero.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_opcode;
			thr_q <= (in_opcode == OP_OFF) ? '0 : in_thrust;
		end
	end

	assign t_neg = thr_q[THRUST_W-1];
	assign t_pos = !thr_q[THRUST_W-1] && (thr_q != '0);
	assign mag   = t_neg ? (~thr_q + THRUST_W'(1)) : thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pos_q <= 1'b0;
			prev_neg_q <= 1'b0;
			relay_q    <= 1'b0;
		end else begin
			if (cmd.commit) begin
				prev_pos_q <= t_pos;
				prev_neg_q <= t_neg;
			end
			if (cmd.emit && cmd.act == ACT_RELAY) begin
				relay_q <= cmd.relay_val;
			end
		end
	end

	// Restoring divider, one quotient bit per cycle. The dividend shifts out of quo_q
	// at the top while quotient bits shift in at the bottom.
	assign trial = {rem_q, quo_q[PROD_W-1]};
	assign diff  = trial - {1'b0, thrust_lim_q};
	assign qbit  = (trial >= {1'b0, thrust_lim_q});
	assign div_busy = (div_cnt_q != '0);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= PROD_W'(mag[CFG_MAX_W-1:0]) * PROD_W'(pw_span_q);
		end
		if (cmd.div_start) begin
			quo_q <= prod_q;
			rem_q <= '0;
		end else if (div_busy) begin
			quo_q <= {quo_q[PROD_W-2:0], qbit};
			rem_q <= qbit ? diff[CFG_MAX_W-1:0] : trial[CFG_MAX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_start) begin
			div_cnt_q <= DIV_CNT_W'(PROD_W);
		end else if (div_busy) begin
			div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_last     <= cmd.last;
			out_error    <= 1'b0;
			out_relay_on <= relay_q;
			case (cmd.act)
				ACT_ERR: begin
					out_pulse_width <= '0;
					out_wait_us     <= '0;
					out_error       <= 1'b1;
				end
				ACT_ARM: begin
					out_pulse_width <= PW_W'(zero_pw_q);
					out_wait_us     <= arm_wait_q;
				end
				ACT_ZERO: begin
					out_pulse_width <= PW_W'(zero_pw_q);
					out_wait_us     <= zero_wait_q;
				end
				ACT_RELAY: begin
					out_pulse_width <= PW_W'(zero_pw_q);
					out_relay_on    <= cmd.relay_val;
					out_wait_us     <= relay_wait_q;
				end
				ACT_SET: begin
					out_pulse_width <= PW_W'(zero_pw_q) + PW_W'(quo_q[CFG_PW_W-1:0]);
					out_wait_us     <= '0;
				end
				default: begin
					out_pulse_width <= '0;
					out_wait_us     <= '0;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		stat          = '0;
		stat.opcode   = op_q;
		stat.t_pos    = t_pos;
		stat.t_neg    = t_neg;
		stat.prev_pos = prev_pos_q;
		stat.prev_neg = prev_neg_q;
		stat.oor      = (mag > {1'b0, thrust_lim_q});
		stat.div_busy = div_busy;
		stat.out_free = out_free;
	end

`ifndef SYNTHESIS
	// The relay only turns to reverse once a negative thrust has been stored.
	a_reverse_needs_neg: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(relay_q) |-> prev_neg_q)
		else $error("relay reversed without a stored negative thrust");

	// The power-off action follows the stop sequence, so the relay is already forward.
	a_off_forward: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.act == ACT_OFF) |-> !relay_q)
		else $error("power-off action with the relay reversed");

	// An in-range magnitude never scales beyond the span.
	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(div_busy) |-> (quo_q[PROD_W-1:CFG_PW_W] == '0))
		else $error("scaled pulse width exceeds the span field");
`endif

endmodule

// ===== sv/rets_ctrl.sv =====
// Controller: decodes a command into pending actions and issues them one at a time.
module rets_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rets_pkg::dp_stat_t  stat,
	output rets_pkg::ctrl_cmd_t cmd
);
	import rets_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_MUL,
		S_DIVST,
		S_DIV,
		S_EMIT
	} state_t;

	state_t             state_q;
	logic [NUM_ACT-1:0] pend_q;
	logic               relay_val_q;

	logic [NUM_ACT-1:0] dec_pend;
	logic               dec_relay;
	logic               dec_commit;
	logic [NUM_ACT-1:0] first;
	logic [NUM_ACT-1:0] rest;
	act_t               first_act;

	// Decode of the latched command against the stored direction.
	always_comb begin
		dec_pend   = '0;
		dec_relay  = 1'b0;
		dec_commit = 1'b0;
		if (stat.opcode == OP_ARM) begin
			dec_pend[ACT_ARM] = 1'b1;
		end else if (stat.opcode == OP_SET && stat.oor) begin
			dec_pend[ACT_ERR] = 1'b1;
		end else if (stat.opcode == OP_SET || stat.opcode == OP_OFF) begin
			dec_commit = 1'b1;
			dec_pend[ACT_OFF] = (stat.opcode == OP_OFF);
			if (stat.t_pos) begin
				dec_pend[ACT_ZERO]  = stat.prev_neg;
				dec_pend[ACT_RELAY] = stat.prev_neg;
				dec_pend[ACT_SET]   = 1'b1;
			end else if (stat.t_neg) begin
				dec_pend[ACT_ZERO]  = stat.prev_pos;
				dec_pend[ACT_RELAY] = !stat.prev_neg;
				dec_pend[ACT_SET]   = 1'b1;
				dec_relay           = 1'b1;
			end else begin
				dec_pend[ACT_ZERO]  = stat.prev_pos || stat.prev_neg;
				dec_pend[ACT_RELAY] = stat.prev_pos || stat.prev_neg;
			end
		end
	end

	// The lowest pending bit is the next action in sequence order.
	assign first = pend_q & (~pend_q + NUM_ACT'(1));
	assign rest  = pend_q & ~first;

	always_comb begin
		if (first[ACT_ERR]) begin
			first_act = ACT_ERR;
		end else if (first[ACT_ARM]) begin
			first_act = ACT_ARM;
		end else if (first[ACT_ZERO]) begin
			first_act = ACT_ZERO;
		end else if (first[ACT_RELAY]) begin
			first_act = ACT_RELAY;
		end else if (first[ACT_SET]) begin
			first_act = ACT_SET;
		end else begin
			first_act = ACT_OFF;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd           = '0;
		cmd.load      = in_valid && (state_q == S_IDLE);
		cmd.commit    = (state_q == S_DECODE) && dec_commit;
		cmd.mul       = (state_q == S_MUL);
		cmd.div_start = (state_q == S_DIVST);
		cmd.emit      = (state_q == S_EMIT) && (pend_q != '0) && stat.out_free;
		cmd.act       = first_act;
		cmd.last      = (rest == '0);
		cmd.relay_val = relay_val_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_q      <= '0;
			relay_val_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					pend_q      <= dec_pend;
					relay_val_q <= dec_relay;
					state_q     <= dec_pend[ACT_SET] ? S_MUL : S_EMIT;
				end
				S_MUL: begin
					state_q <= S_DIVST;
				end
				S_DIVST: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (!stat.div_busy) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (pend_q == '0) begin
						state_q <= S_IDLE;
					end else if (stat.out_free) begin
						pend_q <= rest;
						if (rest == '0) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// A result is only written into a free result register.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free)
		else $error("result issued while the result register is occupied");

	// The divider always starts on a freshly registered product.
	a_div_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> $past(cmd.mul))
		else $error("divider started without a new product");

	// The pulse is set only once the scaling divider has finished.
	a_set_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.act == ACT_SET) |-> !stat.div_busy)
		else $error("set action issued while the divider is running");
`endif

endmodule

// ===== sv/reversible_esc_thrust_sequencer_unit.sv =====
// Top level of the reversible ESC thrust sequencer: stream ports, controller and datapath.
//
// Each command on the slave stream (arm, set a signed thrust, or power off) becomes
// up to three actions on the master stream, each a pulse width, a relay level and a
// hold time; a change of direction or a stop first drives the zero pulse, then
// switches the relay, then sets any new pulse. One command is handled at a time.
// A set command that produces a new pulse passes through decode, multiply, divider
// start and divide before its results are issued, and each result also waits while
// the output register is still occupied: the pulse width comes from a restoring
// divider that retires one quotient bit per cycle over the 28-bit product of
// magnitude and span. Arm, stop, power-off and rejected commands go from decode
// straight to their results. The last result of a command may wait in the output
// register while the next command is accepted. Configuration registers are
// written at any clock edge with cfg_we high and should only change while no command
// is in progress.
module reversible_esc_thrust_sequencer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rets_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [rets_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [23:0]                     s_tdata,   // [16:0] thrust (signed)
	input  logic [1:0]                      s_tuser,   // [1:0] opcode
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [39:0]                     m_tdata,   // [12:0] pulse_width, [13] relay_on, [37:14] wait_us
	output logic [0:0]                      m_tuser,   // [0] error
	output logic                            m_tlast
);
	import rets_pkg::*;

	ctrl_cmd_t         cmd;
	dp_stat_t          stat;
	logic [PW_W-1:0]   pulse_width;
	logic              relay_on;
	logic [WAIT_W-1:0] wait_us;
	logic              error;

	rets_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rets_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_we          (cfg_we),
		.cfg_addr        (cfg_addr),
		.cfg_wdata       (cfg_wdata),
		.in_opcode       (s_tuser),
		.in_thrust       (s_tdata[THRUST_W-1:0]),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_pulse_width (pulse_width),
		.out_relay_on    (relay_on),
		.out_wait_us     (wait_us),
		.out_error       (error),
		.out_last        (m_tlast)
	);

	assign m_tdata = {2'b00, wait_us, relay_on, pulse_width};
	assign m_tuser = error;

endmodule
